>>> hw/rtl/zsc_pkg.sv
// ----------------------------------------------------------------------------
// zsc_pkg
// shared widths, types and codes for the rolling z-score pair signal core
// ----------------------------------------------------------------------------
`default_nettype none

package zsc_pkg;

   // window length, number of earlier spreads scored against
   localparam int WINDOW   = 8;
   localparam int WIN_LOG  = $clog2(WINDOW);
   localparam int SLOT_W   = WIN_LOG;
   localparam int FILL_W   = $clog2(WINDOW + 1);

   localparam int PRICE_W  = 24;
   localparam int SPREAD_W = PRICE_W + 1;
   localparam int MAG_W    = PRICE_W;
   localparam int SQ1_W    = 2 * MAG_W;
   localparam int SUM_W    = SPREAD_W + WIN_LOG;
   localparam int SQ_W     = SQ1_W + WIN_LOG;
   localparam int DEV_W    = SUM_W + 1;
   localparam int MUL_W    = DEV_W - 1;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int VAR_W    = SQ1_W + 2 * WIN_LOG;
   localparam int VHI_W    = VAR_W - MUL_W;
   localparam int THR_W    = 12;
   localparam int T2_W     = 2 * THR_W;
   localparam int CMP_W    = T2_W + VAR_W;
   localparam int FRAC_SHIFT = 16;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

   typedef logic signed [SPREAD_W-1:0] spread_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [SQ1_W-1:0]           sq1_type;
   typedef logic [SQ_W-1:0]            sqsum_type;

   typedef enum logic [1:0] {
      SIG_NONE  = 2'd0,
      SIG_SHORT = 2'd1,
      SIG_LONG  = 2'd2
   } sig_type;

   // window update request from the sequencer
   typedef struct packed {
      logic       en;
      spread_type cur;
      sq1_type    sq_cur;
      sq1_type    sq_old;
   } win_upd_type;

   // window status seen by the sequencer
   typedef struct packed {
      logic       full;
      spread_type old;
      sum_type    sum;
      sqsum_type  sqsum;
   } win_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/zsc_req_if.sv
// ----------------------------------------------------------------------------
// zsc_req_if
// price pair channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface zsc_req_if import zsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] price_a;
   logic [PRICE_W-1:0] price_b;

   modport source (output valid, output price_a, output price_b, input ready);
   modport sink   (input valid, input price_a, input price_b, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/zsc_rsp_if.sv
// ----------------------------------------------------------------------------
// zsc_rsp_if
// signal result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface zsc_rsp_if import zsc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] signal;
   logic       window_ready;
   logic       flat_window;

   modport source (output valid, output signal, output window_ready,
                   output flat_window, input ready);
   modport sink   (input valid, input signal, input window_ready,
                   input flat_window, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/zsc_mul.sv
// ----------------------------------------------------------------------------
// zsc_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module zsc_mul import zsc_pkg::*; (
   input  wire logic              clock,
   input  wire logic [MUL_W-1:0]  op_a,
   input  wire logic [MUL_W-1:0]  op_b,
   output logic      [PROD_W-1:0] prod_ff
);

   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/zsc_win.sv
// ----------------------------------------------------------------------------
// zsc_win
// spread ring with running sum and sum of squares
// ----------------------------------------------------------------------------
`default_nettype none

module zsc_win import zsc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire win_upd_type  upd,
   output win_stat_type      stat
);

   spread_type           ring_ff [WINDOW];
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   sum_type              sum_ff, sum_in;
   sqsum_type            sqsum_ff, sqsum_in;
   logic                 full;

   assign full = (fill_ff == FILL_W'(WINDOW));

   always_comb begin
      slot_in  = slot_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      sqsum_in = sqsum_ff;
      if (upd.en) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (full) begin
            // oldest spread leaves the window
            sum_in   = sum_ff + SUM_W'(upd.cur) - SUM_W'(ring_ff[slot_ff]);
            sqsum_in = sqsum_ff + SQ_W'(upd.sq_cur) - SQ_W'(upd.sq_old);
         end else begin
            fill_in  = fill_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(upd.cur);
            sqsum_in = sqsum_ff + SQ_W'(upd.sq_cur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         sqsum_ff <= '0;
      end else begin
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         sqsum_ff <= sqsum_in;
      end
   end

   // ring entries are only read once every slot has been written
   always_ff @(posedge clock) begin
      if (upd.en) begin
         ring_ff[slot_ff] <= upd.cur;
      end
   end

   assign stat.full  = full;
   assign stat.old   = ring_ff[slot_ff];
   assign stat.sum   = sum_ff;
   assign stat.sqsum = sqsum_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rolling_zscore_pair_signal_core.sv
// ----------------------------------------------------------------------------
// rolling_zscore_pair_signal_core
// words: a new price word is accepted only in ST_IDLE, once the last word has left ST_FIN
//   with its result registered; the single shared multiplier forms
//   seven products per word (three squares, the deviation square, the
//   threshold square and a two-part threshold times variance product)
// reset: synchronous, active high; clears window count, slot, sums and
//   threshold (back to 1.0); ring contents need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_zscore_pair_signal_core import zsc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   zsc_req_if.sink           req_chan,
   zsc_rsp_if.source         rsp_chan,
   input  wire logic         csr_wr_en,
   input  wire logic [THR_W-1:0] csr_wr_data
);

   // one-hot sequencer, at most one multiplier issue per step
   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,  // waiting for a price word
      ST_CUR  = 10'b00_0000_0010,  // square of current spread, form deviation
      ST_OLD  = 10'b00_0000_0100,  // square of the spread leaving the window
      ST_SUM  = 10'b00_0000_1000,  // square of the running sum
      ST_DEV  = 10'b00_0001_0000,  // square of deviation, form variance
      ST_T2   = 10'b00_0010_0000,  // threshold squared
      ST_RLO  = 10'b00_0100_0000,  // threshold^2 times low part of variance
      ST_RHI  = 10'b00_1000_0000,  // threshold^2 times high part of variance
      ST_ACC  = 10'b01_0000_0000,  // fold high partial product in
      ST_FIN  = 10'b10_0000_0000   // compare, emit result, update window
   } state_type;

   state_type            state_ff, state_in;

   // threshold register
   logic [THR_W-1:0]     thr_ff, thr_in;

   // working registers
   spread_type           cur_ff, cur_in;
   logic signed [DEV_W-1:0] dev_ff, dev_in;
   sq1_type              sqcur_ff;
   sq1_type              sqold_ff;
   logic [VAR_W-1:0]     var_ff, var_in;
   logic [PROD_W-1:0]    lhs_ff;
   logic [T2_W-1:0]      t2_ff;
   logic [CMP_W-1:0]     rhs_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   sig_type              rsp_sig_ff, rsp_sig_in;
   logic                 rsp_rdy_ff, rsp_rdy_in;
   logic                 rsp_flat_ff, rsp_flat_in;

   // multiplier
   logic [MUL_W-1:0]     op_a, op_b;
   logic [PROD_W-1:0]    prod_ff;

   // window store
   win_upd_type          win_upd;
   win_stat_type         win_stat;

   logic                 accept;
   logic                 out_free;
   logic [MAG_W-1:0]     cur_mag, old_mag;
   logic [SUM_W-2:0]     sum_mag;
   logic [MUL_W-1:0]     dev_mag;
   logic [CMP_W-1:0]     lhs_cmp;
   logic                 above;
   logic                 flat;

   localparam logic signed [DEV_W-1:0] WIN_DEV = DEV_W'(WINDOW);
   localparam logic [VAR_W-1:0]        WIN_VAR = VAR_W'(WINDOW);

   zsc_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   zsc_win u_win (
      .clock (clock),
      .reset (reset),
      .upd   (win_upd),
      .stat  (win_stat)
   );

   // handshakes: a finished result may wait while the next word comes in
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // magnitudes of signed quantities
   assign cur_mag = cur_ff[SPREAD_W-1] ? MAG_W'(-cur_ff) : MAG_W'(cur_ff);
   assign old_mag = win_stat.old[SPREAD_W-1] ? MAG_W'(-win_stat.old)
                                             : MAG_W'(win_stat.old);
   assign sum_mag = win_stat.sum[SUM_W-1] ? (SUM_W-1)'(-win_stat.sum)
                                          : (SUM_W-1)'(win_stat.sum);
   assign dev_mag = dev_ff[DEV_W-1] ? MUL_W'(-dev_ff) : MUL_W'(dev_ff);

   // spread and deviation
   assign cur_in = $signed({1'b0, req_chan.price_a}) - $signed({1'b0, req_chan.price_b});
   assign dev_in = WIN_DEV * DEV_W'(cur_ff) - DEV_W'(win_stat.sum);

   // variance scaled by window squared: N*sumsq - sum^2
   assign var_in = WIN_VAR * VAR_W'(win_stat.sqsum) - prod_ff[VAR_W-1:0];

   // z^2 > thr^2 test, threshold in q4.8 so deviation side gets 16 bits
   assign lhs_cmp = CMP_W'(lhs_ff) << FRAC_SHIFT;
   assign above   = lhs_cmp > rhs_ff;
   assign flat    = (var_ff == '0);

   // multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_CUR: begin
            op_a = MUL_W'(cur_mag);
            op_b = MUL_W'(cur_mag);
         end
         ST_OLD: begin
            op_a = MUL_W'(old_mag);
            op_b = MUL_W'(old_mag);
         end
         ST_SUM: begin
            op_a = MUL_W'(sum_mag);
            op_b = MUL_W'(sum_mag);
         end
         ST_DEV: begin
            op_a = dev_mag;
            op_b = dev_mag;
         end
         ST_T2: begin
            op_a = MUL_W'(thr_ff);
            op_b = MUL_W'(thr_ff);
         end
         ST_RLO: begin
            op_a = MUL_W'(prod_ff[T2_W-1:0]);
            op_b = var_ff[MUL_W-1:0];
         end
         ST_RHI: begin
            op_a = MUL_W'(t2_ff);
            op_b = MUL_W'(var_ff[VAR_W-1:MUL_W]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // sequencer and result forming
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sig_in   = rsp_sig_ff;
      rsp_rdy_in   = rsp_rdy_ff;
      rsp_flat_in  = rsp_flat_ff;
      win_upd.en     = 1'b0;
      win_upd.cur    = cur_ff;
      win_upd.sq_cur = sqcur_ff;
      win_upd.sq_old = sqold_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CUR;
         ST_CUR:  state_in = ST_OLD;
         ST_OLD:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_DEV;
         ST_DEV:  state_in = ST_T2;
         ST_T2:   state_in = ST_RLO;
         ST_RLO:  state_in = ST_RHI;
         ST_RHI:  state_in = ST_ACC;
         ST_ACC:  state_in = ST_FIN;
         ST_FIN: begin
            // hold here while the previous word is still unread
            if (out_free) begin
               state_in     = ST_IDLE;
               win_upd.en   = 1'b1;
               rsp_valid_in = 1'b1;
               if (win_stat.full) begin
                  rsp_rdy_in  = 1'b1;
                  rsp_flat_in = flat;
                  if (flat || !above) begin
                     rsp_sig_in = SIG_NONE;
                  end else if (dev_ff[DEV_W-1]) begin
                     rsp_sig_in = SIG_LONG;
                  end else begin
                     rsp_sig_in = SIG_SHORT;
                  end
               end else begin
                  // window still filling
                  rsp_rdy_in  = 1'b0;
                  rsp_flat_in = 1'b0;
                  rsp_sig_in  = SIG_NONE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign thr_in = csr_wr_en ? csr_wr_data : thr_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, loaded in the step that consumes each product
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= cur_in;
      end
      if (state_ff == ST_CUR) begin
         dev_ff <= dev_in;
      end
      if (state_ff == ST_OLD) begin
         sqcur_ff <= prod_ff[SQ1_W-1:0];
      end
      if (state_ff == ST_SUM) begin
         sqold_ff <= prod_ff[SQ1_W-1:0];
      end
      if (state_ff == ST_DEV) begin
         var_ff <= var_in;
      end
      if (state_ff == ST_T2) begin
         lhs_ff <= prod_ff;
      end
      if (state_ff == ST_RLO) begin
         t2_ff <= prod_ff[T2_W-1:0];
      end
      if (state_ff == ST_RHI) begin
         rhs_ff <= CMP_W'(prod_ff);
      end
      if (state_ff == ST_ACC) begin
         rhs_ff <= rhs_ff + (CMP_W'(prod_ff) << MUL_W);
      end
      rsp_sig_ff  <= rsp_sig_in;
      rsp_rdy_ff  <= rsp_rdy_in;
      rsp_flat_ff <= rsp_flat_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.signal       = rsp_sig_ff;
   assign rsp_chan.window_ready = rsp_rdy_ff;
   assign rsp_chan.flat_window  = rsp_flat_ff;

endmodule

`default_nettype wire
